[hw/rtl/scta_pkg.sv]
// shared types, scan code constants and the key translation rom
// for the scan code to ascii block; no dependencies

package scta_pkg;

    // character store depth default
    localparam int FIFO_DEPTH_DEF = 16;
    // entries in the op queue between front and back
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);

    // set-1 make codes with special handling
    localparam logic [6:0] SC_LSHIFT = 7'h2A;
    localparam logic [6:0] SC_RSHIFT = 7'h36;
    localparam logic [6:0] SC_CAPS   = 7'h3A;
    localparam logic [6:0] SC_NUM    = 7'h45;
    localparam logic [6:0] SC_SCROLL = 7'h46;

    // lock masks, same bit order as the led bits
    localparam logic [2:0] LK_SCROLL = 3'b001;
    localparam logic [2:0] LK_NUM    = 3'b010;
    localparam logic [2:0] LK_CAPS   = 3'b100;

    localparam logic [7:0] CHAR_NONE = 8'hFF;

    // operations handed from front to back
    typedef enum logic [3:0] {
        OP_NOP,
        OP_READ,
        OP_PRESS,
        OP_LSHIFT_DN,
        OP_LSHIFT_UP,
        OP_RSHIFT_DN,
        OP_RSHIFT_UP,
        OP_LOCK_DN,
        OP_LOCK_UP
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [2:0]  lock_mask;
        logic [31:0] rom_word;   // plain, shifted, caps, num from msb down
    } t_op_item;

    // status from back end, used by the top-level checks
    typedef struct packed {
        logic [8:0] count;       // wide enough for the largest depth
        logic       exec;
    } t_back_status;

    // fixed translation rom: plain | shifted | caps | num
    function automatic logic [31:0] key_rom(input logic [6:0] code);
        logic [31:0] w;
        case (code)
            7'h02: w = 32'h31210000;
            7'h03: w = 32'h32400000;
            7'h04: w = 32'h33230000;
            7'h05: w = 32'h34240000;
            7'h06: w = 32'h35250000;
            7'h07: w = 32'h365e0000;
            7'h08: w = 32'h37260000;
            7'h09: w = 32'h382a0000;
            7'h0A: w = 32'h39280000;
            7'h0B: w = 32'h30290000;
            7'h0C: w = 32'h2d5f0000;
            7'h0D: w = 32'h3d2b0000;
            7'h10: w = 32'h71515100;
            7'h11: w = 32'h77575700;
            7'h12: w = 32'h65454500;
            7'h13: w = 32'h72525200;
            7'h14: w = 32'h74545400;
            7'h15: w = 32'h79595900;
            7'h16: w = 32'h75555500;
            7'h17: w = 32'h69494900;
            7'h18: w = 32'h6f4f4f00;
            7'h19: w = 32'h70505000;
            7'h1A: w = 32'h5b7b0000;
            7'h1B: w = 32'h5d7d0000;
            7'h1C: w = 32'h0d0d0d0d;
            7'h1E: w = 32'h61414100;
            7'h1F: w = 32'h73535300;
            7'h20: w = 32'h64444400;
            7'h21: w = 32'h66464600;
            7'h22: w = 32'h67474700;
            7'h23: w = 32'h68484800;
            7'h24: w = 32'h6a4a4a00;
            7'h25: w = 32'h6b4b4b00;
            7'h26: w = 32'h6c4c4c00;
            7'h27: w = 32'h3b3a0000;
            7'h28: w = 32'h27220000;
            7'h29: w = 32'h607e0000;
            7'h2B: w = 32'h5c7c0000;
            7'h2C: w = 32'h7a5a5a00;
            7'h2D: w = 32'h78585800;
            7'h2E: w = 32'h63434300;
            7'h2F: w = 32'h76565600;
            7'h30: w = 32'h62424200;
            7'h31: w = 32'h6e4e4e00;
            7'h32: w = 32'h6d4d4d00;
            7'h33: w = 32'h2c3c0000;
            7'h34: w = 32'h2e3e0000;
            7'h35: w = 32'h2f3f0000;
            7'h39: w = 32'h20202020;
            7'h47: w = 32'h00000037;
            7'h48: w = 32'h00000038;
            7'h49: w = 32'h00000039;
            7'h4A: w = 32'h2d2d2d2d;
            7'h4B: w = 32'h00000034;
            7'h4C: w = 32'h00000035;
            7'h4D: w = 32'h00000036;
            7'h4E: w = 32'h2b2b2b2b;
            7'h4F: w = 32'h00000031;
            7'h50: w = 32'h00000032;
            7'h51: w = 32'h00000033;
            7'h52: w = 32'h00000030;
            7'h53: w = 32'h0000002e;
            default: w = 32'h00000000;
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/scan_code_to_ascii_fifo_core.sv]
// scan code to ascii translator top level: front classifier, op queue,
// back end with character fifo; depends on scta_pkg and all scta modules
// throughput: one beat per cycle unless stalled, set by the single back-end exec stage
// path: each op waits in the two-entry queue, then executes and its result is
//   registered in the back-end output register; a stalled output keeps it queued
// reset: synchronous, active low; clears key, lock and fifo pointer state,
//   the character store itself is not cleared

module scan_code_to_ascii_fifo_core
    import scta_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] key code
    input  logic        i_s_tuser,   // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] read_char, [10:8] led_bits, [11] led_write,
                                     // [16:12] fill_count, [17] dropped, [23:18] zero
    output logic        o_m_tuser    // [0] char_valid
);

    t_op_item            w_front_item;
    t_op_item            w_back_item;
    logic                w_q_full;
    logic                w_q_valid;
    logic                w_pop;
    logic                w_push;
    logic [QUEUE_CW-1:0] w_q_level;
    t_back_status        w_status;
    logic [7:0]          w_read_char;
    logic [2:0]          w_led_bits;
    logic                w_led_write;
    logic [4:0]          w_fill;
    logic                w_dropped;

    assign o_s_tready = !w_q_full;
    assign w_push     = i_s_tvalid && !w_q_full;

    scta_front u_front (
        .i_cmd      (i_s_tuser),
        .i_key_byte (i_s_tdata),
        .o_item     (w_front_item)
    );

    scta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_back_item),
        .o_level (w_q_level)
    );

    scta_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_item       (w_back_item),
        .o_pop        (w_pop),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_read_char  (w_read_char),
        .o_char_valid (o_m_tuser),
        .o_led_bits   (w_led_bits),
        .o_led_write  (w_led_write),
        .o_fill_count (w_fill),
        .o_dropped    (w_dropped),
        .o_status     (w_status)
    );

    assign o_m_tdata = {6'b000000, w_dropped, w_fill, w_led_write, w_led_bits, w_read_char};

    // fifo occupancy never passes its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.count <= 9'(FIFO_DEPTH))
        else $error("character fifo count above depth");

    // queue level stays within its slots and never pops empty
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_level <= QUEUE_CW'(QUEUE_DEPTH)) && (!w_status.exec || w_q_valid))
        else $error("op queue level or pop out of range");

    // a result not taken from the fifo carries the empty marker
    a_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[7:0] == CHAR_NONE)
        else $error("read_char not 0xff without a popped character");

    // a drop is only reported with the fifo full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[17] |-> o_m_tdata[16:12] == 5'(FIFO_DEPTH))
        else $error("drop reported with room in the fifo");

endmodule

[hw/rtl/scta_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies

module scta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/scta_front.sv]
// front end: classifies input beats into back-end operations and
// looks up the rom word; depends on scta_pkg

module scta_front
    import scta_pkg::*;
(
    input  logic     i_cmd,
    input  logic [7:0] i_key_byte,
    output t_op_item o_item
);

    logic [6:0] w_key;

    assign w_key = i_key_byte[6:0];

    // decode command, make and break codes
    always_comb begin
        o_item.op        = OP_NOP;
        o_item.lock_mask = 3'b000;
        o_item.rom_word  = key_rom(w_key);
        if (i_cmd) begin
            o_item.op = OP_READ;
        end else if (!i_key_byte[7]) begin
            case (w_key)
                SC_LSHIFT: o_item.op = OP_LSHIFT_DN;
                SC_RSHIFT: o_item.op = OP_RSHIFT_DN;
                SC_CAPS: begin
                    o_item.op        = OP_LOCK_DN;
                    o_item.lock_mask = LK_CAPS;
                end
                SC_NUM: begin
                    o_item.op        = OP_LOCK_DN;
                    o_item.lock_mask = LK_NUM;
                end
                SC_SCROLL: begin
                    o_item.op        = OP_LOCK_DN;
                    o_item.lock_mask = LK_SCROLL;
                end
                default: o_item.op = OP_PRESS;
            endcase
        end else begin
            case (w_key)
                SC_LSHIFT: o_item.op = OP_LSHIFT_UP;
                SC_RSHIFT: o_item.op = OP_RSHIFT_UP;
                SC_CAPS: begin
                    o_item.op        = OP_LOCK_UP;
                    o_item.lock_mask = LK_CAPS;
                end
                SC_NUM: begin
                    o_item.op        = OP_LOCK_UP;
                    o_item.lock_mask = LK_NUM;
                end
                SC_SCROLL: begin
                    o_item.op        = OP_LOCK_UP;
                    o_item.lock_mask = LK_SCROLL;
                end
                default: o_item.op = OP_NOP;
            endcase
        end
    end

endmodule

[hw/rtl/scta_queue.sv]
// short op queue between front and back end
// depends on scta_pkg

module scta_queue
    import scta_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_op_item            i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output t_op_item            o_item,
    output logic [QUEUE_CW-1:0] o_level
);

    t_op_item            r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_CW-1:0] r_level;
    logic [QUEUE_AW-1:0] n_wptr;
    logic [QUEUE_AW-1:0] n_rptr;
    logic [QUEUE_CW-1:0] n_level;

    // pointer and level update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_level = r_level;
        if (i_push) begin
            n_wptr = (r_wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_level = r_level + 1'b1;
        end else if (!i_push && i_pop) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

    assign o_full  = (r_level == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_level != '0);
    assign o_item  = r_slot[r_rptr];
    assign o_level = r_level;

endmodule

[hw/rtl/scta_back.sv]
// back end: key state, lock leds, character fifo and output register
// depends on scta_pkg and scta_ram

module scta_back
    import scta_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_op_item     i_item,
    output logic         o_pop,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [7:0]   o_read_char,
    output logic         o_char_valid,
    output logic [2:0]   o_led_bits,
    output logic         o_led_write,
    output logic [4:0]   o_fill_count,
    output logic         o_dropped,
    output t_back_status o_status
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic          r_shift_l;
    logic          r_shift_r;
    logic [2:0]    r_lock_active;
    logic [2:0]    r_lock_held;
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          n_shift_l;
    logic          n_shift_r;
    logic [2:0]    n_lock_active;
    logic [2:0]    n_lock_held;
    logic [PW-1:0] n_wptr;
    logic [PW-1:0] n_rptr;
    logic [CW-1:0] n_count;

    logic          r_out_valid;
    logic          r_from_ram;
    logic          r_led_write;
    logic          r_dropped;
    logic [4:0]    r_fill;
    logic          n_from_ram;
    logic          n_led_write;
    logic          n_dropped;

    logic          w_exec;
    logic          w_we;
    logic          w_re;
    logic [7:0]    w_char;
    logic [7:0]    w_ram_q;

    // one op executes whenever the output slot frees up
    assign w_exec = i_valid && (!r_out_valid || i_out_ready);
    assign o_pop  = w_exec;

    // translate the rom word with current shift and lock state
    always_comb begin
        if (r_shift_l || r_shift_r) begin
            w_char = i_item.rom_word[23:16];
        end else begin
            w_char = i_item.rom_word[31:24];
            if (i_item.rom_word[15:8] != 8'h00 && (r_lock_active & LK_CAPS) != 3'b000) begin
                w_char = i_item.rom_word[15:8];
            end
            if (i_item.rom_word[7:0] != 8'h00 && (r_lock_active & LK_NUM) != 3'b000) begin
                w_char = i_item.rom_word[7:0];
            end
        end
    end

    // execute one operation
    always_comb begin
        n_shift_l     = r_shift_l;
        n_shift_r     = r_shift_r;
        n_lock_active = r_lock_active;
        n_lock_held   = r_lock_held;
        n_wptr        = r_wptr;
        n_rptr        = r_rptr;
        n_count       = r_count;
        n_from_ram    = 1'b0;
        n_led_write   = 1'b0;
        n_dropped     = 1'b0;
        w_we          = 1'b0;
        w_re          = 1'b0;
        case (i_item.op)
            OP_READ: begin
                if (r_count != '0) begin
                    w_re       = w_exec;
                    n_from_ram = 1'b1;
                    n_rptr     = (r_rptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
                    n_count    = r_count - 1'b1;
                end
            end
            OP_PRESS: begin
                if (r_count < CW'(FIFO_DEPTH)) begin
                    w_we    = w_exec;
                    n_wptr  = (r_wptr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                    n_count = r_count + 1'b1;
                end else begin
                    n_dropped = 1'b1;
                end
            end
            OP_LSHIFT_DN: n_shift_l = 1'b1;
            OP_LSHIFT_UP: n_shift_l = 1'b0;
            OP_RSHIFT_DN: n_shift_r = 1'b1;
            OP_RSHIFT_UP: n_shift_r = 1'b0;
            OP_LOCK_DN: begin
                if ((r_lock_held & i_item.lock_mask) == 3'b000) begin
                    n_lock_active = r_lock_active ^ i_item.lock_mask;
                    n_lock_held   = r_lock_held | i_item.lock_mask;
                    n_led_write   = 1'b1;
                end
            end
            OP_LOCK_UP: n_lock_held = r_lock_held & ~i_item.lock_mask;
            default: ;
        endcase
    end

    // key state and fifo pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_l     <= 1'b0;
            r_shift_r     <= 1'b0;
            r_lock_active <= 3'b000;
            r_lock_held   <= 3'b000;
            r_wptr        <= '0;
            r_rptr        <= '0;
            r_count       <= '0;
        end else if (w_exec) begin
            r_shift_l     <= n_shift_l;
            r_shift_r     <= n_shift_r;
            r_lock_active <= n_lock_active;
            r_lock_held   <= n_lock_held;
            r_wptr        <= n_wptr;
            r_rptr        <= n_rptr;
            r_count       <= n_count;
        end
    end

    // output register; read data lands in the ram output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_from_ram  <= n_from_ram;
            r_led_write <= n_led_write;
            r_dropped   <= n_dropped;
            r_fill      <= 5'(n_count);
        end
    end

    scta_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_char_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wptr),
        .i_wdata (w_char),
        .i_re    (w_re),
        .i_raddr (r_rptr),
        .o_rdata (w_ram_q)
    );

    // led bits follow the lock state, which only moves on a toggle
    assign o_out_valid  = r_out_valid;
    assign o_read_char  = r_from_ram ? w_ram_q : CHAR_NONE;
    assign o_char_valid = r_from_ram;
    assign o_led_bits   = r_lock_active;
    assign o_led_write  = r_led_write;
    assign o_fill_count = r_fill;
    assign o_dropped    = r_dropped;

    assign o_status.count = 9'(r_count);
    assign o_status.exec  = w_exec;

endmodule

[bench/scan_code_to_ascii_fifo_core_test.sv]
// self-checking bench for scan_code_to_ascii_fifo_core: directed key sequences, then random
// keystrokes, lock cycles, reads and noise; depends on scta_pkg and the core rtl

module scan_code_to_ascii_fifo_core_test;
    import scta_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CHAR_DEPTH    = FIFO_DEPTH_DEF;
    localparam int          RANDOM_BEATS  = 1200;
    localparam int          DRAIN_CYCLES  = 16;
    localparam longint      RUN_LIMIT_NS  = 64'd10_000_000;
    localparam int          MAX_PRINTED   = 100;

    // item kinds carried on the input tuser, release and make flags on tdata bit 7
    localparam logic        CMD_SCAN      = 1'b0;
    localparam logic        CMD_READ      = 1'b1;
    localparam logic        REL_FLAG      = 1'b1;
    localparam logic        MAKE_FLAG     = 1'b0;

    // translation table: plain | shifted | caps | num from msb down
    localparam logic [31:0] KEY_TABLE [128] = '{
        32'h00000000, 32'h00000000, 32'h31210000, 32'h32400000,
        32'h33230000, 32'h34240000, 32'h35250000, 32'h365e0000,
        32'h37260000, 32'h382a0000, 32'h39280000, 32'h30290000,
        32'h2d5f0000, 32'h3d2b0000, 32'h00000000, 32'h00000000,
        32'h71515100, 32'h77575700, 32'h65454500, 32'h72525200,
        32'h74545400, 32'h79595900, 32'h75555500, 32'h69494900,
        32'h6f4f4f00, 32'h70505000, 32'h5b7b0000, 32'h5d7d0000,
        32'h0d0d0d0d, 32'h00000000, 32'h61414100, 32'h73535300,
        32'h64444400, 32'h66464600, 32'h67474700, 32'h68484800,
        32'h6a4a4a00, 32'h6b4b4b00, 32'h6c4c4c00, 32'h3b3a0000,
        32'h27220000, 32'h607e0000, 32'h00000000, 32'h5c7c0000,
        32'h7a5a5a00, 32'h78585800, 32'h63434300, 32'h76565600,
        32'h62424200, 32'h6e4e4e00, 32'h6d4d4d00, 32'h2c3c0000,
        32'h2e3e0000, 32'h2f3f0000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h20202020, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000037,
        32'h00000038, 32'h00000039, 32'h2d2d2d2d, 32'h00000034,
        32'h00000035, 32'h00000036, 32'h2b2b2b2b, 32'h00000031,
        32'h00000032, 32'h00000033, 32'h00000030, 32'h0000002e,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
        32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
    };

    typedef struct packed {
        logic       cmd;
        logic [7:0] code;
    } t_key_beat;

    typedef struct {
        logic [7:0] read_char;
        logic       char_valid;
        logic [2:0] led_bits;
        logic       led_write;
        logic [4:0] fill_count;
        logic       dropped;
    } t_key_result;

    // keyboard state, character queue and the results still owed by the core
    class key_translation_model;
        logic        lshift_down;
        logic        rshift_down;
        logic [2:0]  locks_on;
        logic [2:0]  locks_held;
        logic [2:0]  leds;
        logic [7:0]  chars [CHAR_DEPTH];
        int unsigned wr_idx;
        int unsigned rd_idx;
        int unsigned char_count;
        t_key_result awaited_results [$];
        int unsigned mismatches;
        int unsigned results_seen;

        function new();
            lshift_down  = 1'b0;
            rshift_down  = 1'b0;
            locks_on     = '0;
            locks_held   = '0;
            leds         = '0;
            wr_idx       = 0;
            rd_idx       = 0;
            char_count   = 0;
            mismatches   = 0;
            results_seen = 0;
            foreach (chars[i]) chars[i] = '0;
        endfunction

        // one toggle per press, auto-repeat blocked until release
        function logic press_lock(logic [2:0] mask);
            if ((locks_held & mask) != 0) return 1'b0;
            locks_on   ^= mask;
            leds        = locks_on;
            locks_held |= mask;
            return 1'b1;
        endfunction

        function logic [7:0] map_key(logic [6:0] key);
            logic [31:0] word;
            logic [7:0]  ch;
            word = KEY_TABLE[key];
            if (lshift_down || rshift_down) return word[23:16];
            ch = word[31:24];
            if (word[15:8] != 0 && (locks_on & LK_CAPS) != 0) ch = word[15:8];
            if (word[7:0] != 0 && (locks_on & LK_NUM) != 0) ch = word[7:0];
            return ch;
        endfunction

        // accepted input beat: work out the result it owes
        function void note_beat(logic cmd, logic [7:0] code);
            t_key_result res;
            res = '{read_char: CHAR_NONE, char_valid: 1'b0, led_bits: 3'b0,
                    led_write: 1'b0, fill_count: 5'b0, dropped: 1'b0};
            if (cmd == CMD_READ) begin
                if (char_count != 0) begin
                    res.read_char  = chars[rd_idx];
                    res.char_valid = 1'b1;
                    rd_idx         = (rd_idx + 1) % CHAR_DEPTH;
                    char_count--;
                end
            end else if (code[7] == MAKE_FLAG) begin
                case (code[6:0])
                    SC_LSHIFT: lshift_down = 1'b1;
                    SC_RSHIFT: rshift_down = 1'b1;
                    SC_CAPS:   res.led_write = press_lock(LK_CAPS);
                    SC_NUM:    res.led_write = press_lock(LK_NUM);
                    SC_SCROLL: res.led_write = press_lock(LK_SCROLL);
                    default: begin
                        if (char_count < CHAR_DEPTH) begin
                            chars[wr_idx] = map_key(code[6:0]);
                            wr_idx        = (wr_idx + 1) % CHAR_DEPTH;
                            char_count++;
                        end else begin
                            res.dropped = 1'b1;
                        end
                    end
                endcase
            end else begin
                case (code[6:0])
                    SC_LSHIFT: lshift_down = 1'b0;
                    SC_RSHIFT: rshift_down = 1'b0;
                    SC_CAPS:   locks_held &= ~LK_CAPS;
                    SC_NUM:    locks_held &= ~LK_NUM;
                    SC_SCROLL: locks_held &= ~LK_SCROLL;
                    default: ;
                endcase
            end
            res.led_bits   = leds;
            res.fill_count = char_count[4:0];
            awaited_results.push_back(res);
        endfunction

        task report_mismatch(string field, int unsigned got, int unsigned want);
            if (mismatches < MAX_PRINTED)
                $display("result %0d: %s got 0x%0h, want 0x%0h", results_seen, field, got, want);
            mismatches++;
        endtask

        // accepted output beat against the oldest owed result
        task check_beat(logic [23:0] data, logic user);
            t_key_result want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected beat, tdata", data, 0);
                return;
            end
            want = awaited_results.pop_front();
            if (data[7:0] !== want.read_char)
                report_mismatch("read_char", data[7:0], want.read_char);
            if (user !== want.char_valid)
                report_mismatch("char_valid", user, want.char_valid);
            if (data[10:8] !== want.led_bits)
                report_mismatch("led_bits", data[10:8], want.led_bits);
            if (data[11] !== want.led_write)
                report_mismatch("led_write", data[11], want.led_write);
            if (data[16:12] !== want.fill_count)
                report_mismatch("fill_count", data[16:12], want.fill_count);
            if (data[17] !== want.dropped)
                report_mismatch("dropped", data[17], want.dropped);
            if (data[23:18] !== 6'b0)
                report_mismatch("pad bits", data[23:18], 0);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;   // [7:0] key code
    logic        i_s_tuser;   // [0] cmd
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // [7:0] read_char, [10:8] led_bits, [11] led_write,
                              // [16:12] fill_count, [17] dropped, [23:18] zero
    logic        o_m_tuser;   // [0] char_valid

    key_translation_model key_model;
    t_key_beat            key_beats [$];
    int unsigned          counted_beats;

    scan_code_to_ascii_fifo_core #(
        .FIFO_DEPTH (CHAR_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shift and lock keys never reach the character queue
    function automatic logic is_special(logic [6:0] key);
        return key == SC_LSHIFT || key == SC_RSHIFT || key == SC_CAPS ||
               key == SC_NUM || key == SC_SCROLL;
    endfunction

    function automatic logic [6:0] pick_plain_key();
        logic [6:0] key;
        do begin
            if ($urandom_range(0, 3) != 0) key = 7'($urandom_range(8'h02, 8'h53));
            else key = 7'($urandom_range(0, 127));
        end while (is_special(key));
        return key;
    endfunction

    function automatic logic [6:0] pick_lock_key();
        case ($urandom_range(0, 2))
            0:       return SC_CAPS;
            1:       return SC_NUM;
            default: return SC_SCROLL;
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // every queued beat counts toward the total
    task automatic queue_beat(logic cmd, logic [7:0] code);
        key_beats.push_back('{cmd: cmd, code: code});
        counted_beats++;
    endtask

    // press with optional auto-repeat, then usually a release
    task automatic queue_keystroke();
        logic [6:0] key;
        int unsigned repeats;
        key     = pick_plain_key();
        repeats = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        queue_beat(CMD_SCAN, {MAKE_FLAG, key});
        repeat (repeats) queue_beat(CMD_SCAN, {MAKE_FLAG, key});
        if ($urandom_range(0, 9) != 0) queue_beat(CMD_SCAN, {REL_FLAG, key});
    endtask

    // lock press, repeats while held, a few keys in between, usually a release
    task automatic queue_lock_cycle();
        logic [6:0] key;
        key = pick_lock_key();
        queue_beat(CMD_SCAN, {MAKE_FLAG, key});
        repeat ($urandom_range(0, 2)) queue_beat(CMD_SCAN, {MAKE_FLAG, key});
        repeat ($urandom_range(0, 2)) queue_keystroke();
        if ($urandom_range(0, 6) != 0) queue_beat(CMD_SCAN, {REL_FLAG, key});
    endtask

    task automatic queue_shift_run();
        logic [6:0] key;
        key = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
        queue_beat(CMD_SCAN, {MAKE_FLAG, key});
        repeat ($urandom_range(1, 4)) queue_keystroke();
        if ($urandom_range(0, 7) != 0) queue_beat(CMD_SCAN, {REL_FLAG, key});
    endtask

    task automatic send_key_beat(t_key_beat beat);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= beat.cmd;
        i_s_tdata  <= beat.code;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // beat monitor: inputs are noted before results are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) key_model.note_beat(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) key_model.check_beat(o_m_tdata, o_m_tuser);
        end
    end

    // result sink: random stalls in stretches, two long hold-offs to fill the core
    initial begin : result_sink
        int unsigned sink_cycle;
        int unsigned hold_left;
        int unsigned ready_pct;
        sink_cycle = 0;
        hold_left  = 0;
        ready_pct  = 100;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            sink_cycle++;
            if (sink_cycle == 640 || sink_cycle == 2600) begin
                hold_left = 400;
            end else if (sink_cycle % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 85;
                    2:       ready_pct = 60;
                    default: ready_pct = 30;
                endcase
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < ready_pct) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                if ($urandom_range(0, 39) == 0) hold_left = $urandom_range(10, 40);
                else hold_left = pick_gap();
            end
        end
    end

    // hard stop
    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("scan_code_to_ascii_fifo_core_test: errors");
        $finish;
    end

    initial begin : stimulus
        int unsigned seg_left;
        int unsigned read_pct;
        int unsigned roll;
        int unsigned gap;
        bit          steady;

        key_model  = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser  = CMD_SCAN;
        i_s_tdata  = '0;

        // directed: empty read, blank table entries, locks, repeats, shifts, releases
        queue_beat(CMD_READ, 8'h5A);
        queue_beat(CMD_SCAN, 8'h00);
        queue_beat(CMD_SCAN, 8'h7F);
        queue_beat(CMD_SCAN, 8'h1E);
        queue_beat(CMD_SCAN, {MAKE_FLAG, SC_CAPS});
        queue_beat(CMD_SCAN, {MAKE_FLAG, SC_CAPS});
        queue_beat(CMD_SCAN, 8'h1E);
        queue_beat(CMD_SCAN, 8'h02);
        queue_beat(CMD_SCAN, {REL_FLAG, SC_CAPS});
        queue_beat(CMD_SCAN, {MAKE_FLAG, SC_NUM});
        queue_beat(CMD_SCAN, 8'h47);
        queue_beat(CMD_SCAN, 8'h1C);
        queue_beat(CMD_SCAN, {MAKE_FLAG, SC_SCROLL});
        queue_beat(CMD_SCAN, {REL_FLAG, SC_SCROLL});
        queue_beat(CMD_SCAN, {MAKE_FLAG, SC_SCROLL});
        queue_beat(CMD_SCAN, {REL_FLAG, SC_NUM});
        queue_beat(CMD_SCAN, {MAKE_FLAG, SC_LSHIFT});
        queue_beat(CMD_SCAN, 8'h03);
        queue_beat(CMD_SCAN, 8'h9E);
        queue_beat(CMD_SCAN, {REL_FLAG, SC_LSHIFT});
        queue_beat(CMD_SCAN, {MAKE_FLAG, SC_RSHIFT});
        queue_beat(CMD_SCAN, 8'h10);
        queue_beat(CMD_SCAN, {REL_FLAG, SC_RSHIFT});
        queue_beat(CMD_SCAN, 8'hFF);
        queue_beat(CMD_READ, 8'hFF);
        queue_beat(CMD_READ, {MAKE_FLAG, SC_LSHIFT});

        // random: segments lean toward filling or draining the character queue
        counted_beats = 0;
        seg_left      = 0;
        read_pct      = 0;
        while (counted_beats < RANDOM_BEATS) begin
            if (seg_left == 0) begin
                seg_left = 40;
                case ($urandom_range(0, 3))
                    0:       read_pct = 10;
                    1:       read_pct = 30;
                    2:       read_pct = 50;
                    default: read_pct = 80;
                endcase
            end
            seg_left--;
            if ($urandom_range(0, 99) < read_pct) begin
                queue_beat(CMD_READ, 8'($urandom_range(0, 255)));
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 68) queue_keystroke();
                else if (roll < 80) queue_lock_cycle();
                else if (roll < 90) queue_shift_run();
                else queue_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender: gappy stretches, with every third one back-to-back
        foreach (key_beats[idx]) begin
            steady = ((idx / 150) % 3) == 1;
            gap    = steady ? 0 : pick_gap();
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            send_key_beat(key_beats[idx]);
        end
        i_s_tvalid <= 1'b0;

        while (key_model.awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (key_model.mismatches == 0) begin
            $display("scan_code_to_ascii_fifo_core_test: clean");
        end else begin
            $display("scan_code_to_ascii_fifo_core_test: errors");
        end
        $finish;
    end

endmodule

[scan_code_to_ascii_fifo_core.f]
hw/rtl/scta_pkg.sv
hw/rtl/scta_ram.sv
hw/rtl/scta_front.sv
hw/rtl/scta_queue.sv
hw/rtl/scta_back.sv
hw/rtl/scan_code_to_ascii_fifo_core.sv
bench/scan_code_to_ascii_fifo_core_test.sv
